@@ rtl/core/gsv_pkg.sv @@
// shared constants, codes and types of the gost signature verifier
package gsv_pkg;

  localparam int Q_W        = 15;
  localparam int P_W        = 30;
  localparam int DIG_W      = 64;
  localparam int RS_W       = 16;
  localparam int CFG_AW     = 2;
  localparam int CNT_W      = $clog2(DIG_W + 1);
  localparam int Q_BITS_DEF = 15;
  localparam int P_BITS_DEF = 31;
  localparam int Q_RST      = 3;
  localparam int P_RST      = 7;
  localparam int A_RST      = 1;
  localparam int Y_RST      = 1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_Q = 2'd0,
    CFG_P = 2'd1,
    CFG_A = 2'd2,
    CFG_Y = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIGEST,
    ST_EUCLID,
    ST_U1,
    ST_U2,
    ST_RED_A,
    ST_RED_Y,
    ST_SQR,
    ST_MUL,
    ST_FIN,
    ST_VMOD
  } state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mm_req_t;

endpackage

@@ rtl/core/gsv_modmul.sv @@
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module gsv_modmul #(
  parameter int MW = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gsv_pkg::mm_req_t          req_i,
  input  logic [MW-1:0]             x_i,
  input  logic [MW-1:0]             m_i,
  input  logic [gsv_pkg::DIG_W-1:0] y_i,
  output logic                      done_o,
  output logic [MW-1:0]             res_o
);
  import gsv_pkg::*;

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MW-1:0]    acc_q, acc_d;
  logic [MW-1:0]    x_q, x_d;
  logic [MW-1:0]    m_q, m_d;
  logic [DIG_W-1:0] y_q, y_d;
  logic [MW+1:0]    sum, m1, m2, sub1, sub2;
  logic [MW-1:0]    red;

  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + (y_q[DIG_W-1] ? {2'b00, x_q} : (MW+2)'(0));
    m1   = {2'b00, m_q};
    m2   = {1'b0, m_q, 1'b0};
    sub1 = sum - m1;
    sub2 = sum - m2;
    if (sum >= m2) begin
      red = sub2[MW-1:0];
    end else if (sum >= m1) begin
      red = sub1[MW-1:0];
    end else begin
      red = sum[MW-1:0];
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    m_d    = m_q;
    y_d    = y_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = req_i.nbits;
      acc_d = '0;
      x_d   = x_i;
      m_d   = m_i;
      y_d   = y_i;
    end else if (run_q) begin
      acc_d = red;
      y_d   = y_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    m_q   <= m_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q != '0)
    else $error("modmul running with empty bit count");

  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q) && !run_q)
    else $error("modmul done without a run");

endmodule

@@ rtl/core/gsv_euclid.sv @@
// extended euclid unit with a bit-serial divider, gives the coefficient of h mod q
module gsv_euclid #(
  parameter int QW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] h_i,
  input  logic [QW-1:0] q_i,
  output logic          done_o,
  output logic [QW-1:0] inv_o
);
  import gsv_pkg::*;

  localparam int CW = QW + 2;
  localparam int IW = $clog2(QW);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [QW-1:0]        r1_q, r1_d;
  logic [QW-1:0]        dv_q, dv_d;
  logic [QW-1:0]        rem_q, rem_d;
  logic [QW-1:0]        mod_q, mod_d;
  logic [QW-1:0]        inv_q, inv_d;
  logic signed [CW-1:0] c0_q, c0_d;
  logic signed [CW-1:0] c1_q, c1_d;
  logic signed [CW-1:0] prod_q, prod_d;
  logic [QW:0]          sh, sh_sub;
  logic                 ge;
  logic [QW-1:0]        rem_n;
  logic signed [CW-1:0] prod_n, cnew, qs, cfin;

  always_comb begin
    sh     = {rem_q, dv_q[QW-1]};
    sh_sub = sh - {1'b0, r1_q};
    ge     = sh >= {1'b0, r1_q};
    rem_n  = ge ? sh_sub[QW-1:0] : sh[QW-1:0];
    prod_n = (prod_q <<< 1) + (ge ? c1_q : CW'(0));
    cnew   = c0_q - prod_n;
    qs     = $signed({2'b00, mod_q});
    if (c1_q[CW-1]) begin
      cfin = c1_q + qs;
    end else if (c1_q >= qs) begin
      cfin = c1_q - qs;
    end else begin
      cfin = c1_q;
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r1_d   = r1_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    mod_d  = mod_q;
    inv_d  = inv_q;
    c0_d   = c0_q;
    c1_d   = c1_q;
    prod_d = prod_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = IW'(QW - 1);
      dv_d   = q_i;
      r1_d   = h_i;
      rem_d  = '0;
      mod_d  = q_i;
      c0_d   = CW'(0);
      c1_d   = CW'(1);
      prod_d = CW'(0);
    end else if (run_q) begin
      dv_d   = dv_q << 1;
      rem_d  = rem_n;
      prod_d = prod_n;
      cnt_d  = cnt_q - IW'(1);
      if (cnt_q == '0) begin
        // quotient complete: rotate remainders and coefficients
        r1_d   = rem_n;
        dv_d   = r1_q;
        rem_d  = '0;
        prod_d = CW'(0);
        c0_d   = c1_q;
        c1_d   = cnew;
        cnt_d  = IW'(QW - 1);
        if (rem_n == '0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
          inv_d  = cfin[QW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= r1_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    mod_q  <= mod_d;
    inv_q  <= inv_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign inv_o  = inv_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> r1_q != '0)
    else $error("euclid dividing by zero");

  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q && $past(run_q))
    else $error("euclid done without a run");

endmodule

@@ rtl/core/gost_signature_verify.sv @@
// gost-94 style signature verifier: control, configuration and result registers
//
// usage: write q, p, a and y through the cfg channel (cfg_valid_i/cfg_ready_o,
// cfg_addr_i selects the register, cfg_wdata_i carries the value; ready is
// always high). a request is taken on a rising edge with start_i high and
// busy_o low; it carries digest_i, r_value_i and s_value_i.
// each request gives exactly one result: done_o is high for one cycle with
// sig_valid_o and range_fault_o. the receiver cannot stall; done_o drops
// after that cycle, while sig_valid_o and range_fault_o hold to the next result.
// a range fault is reported in the cycle after the request. otherwise the
// digest reduction runs first, then the euclid unit with its quotient steps;
// each modular product runs in the shared serial multiplier, and the two
// exponentiations take up to 4*Q_BITS such products. busy_o stays high
// until done_o, so one request is in flight at a time; a new request may
// be taken in the done_o cycle.
// reset: q=3, p=7, a=1, y=1, the block idle, no result pending.
module gost_signature_verify #(
  parameter int Q_BITS = gsv_pkg::Q_BITS_DEF,
  parameter int P_BITS = gsv_pkg::P_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [gsv_pkg::DIG_W-1:0]  digest_i,
  input  logic [gsv_pkg::RS_W-1:0]   r_value_i,
  input  logic [gsv_pkg::RS_W-1:0]   s_value_i,
  output logic                       done_o,
  output logic                       sig_valid_o,
  output logic                       range_fault_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gsv_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [gsv_pkg::P_W-1:0]    cfg_wdata_i
);
  import gsv_pkg::*;

  localparam int QW = (Q_BITS < Q_W) ? Q_BITS : Q_W;
  localparam int PW = (P_BITS < P_W) ? P_BITS : P_W;
  localparam int MW = (PW > QW) ? PW : QW;
  localparam int IW = $clog2(QW);

  state_e         state_q, state_d;
  logic [QW-1:0]  q_q;
  logic [PW-1:0]  p_q, a_q, y_q;
  logic [QW-1:0]  r_q, r_d, s_q, s_d;
  logic [QW-1:0]  u1_q, u1_d, u2_q, u2_d;
  logic [MW-1:0]  ba_q, ba_d, by_q, by_d, pa_q, pa_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           sel_q, sel_d;
  logic           done_q, done_d;
  logic           sig_q, sig_d;
  logic           fault_q, fault_d;

  mm_req_t        mm_req;
  logic [MW-1:0]  mm_x, mm_m, mm_res;
  logic [DIG_W-1:0] mm_y;
  logic           mm_done;
  logic           eu_start, eu_done;
  logic [QW-1:0]  eu_h, eu_inv;

  logic           range_bad, p_small, ebit;
  logic [MW-1:0]  one_m, q_m, p_m, base;
  logic [DIG_W-1:0] res_al, inv_al, one_al, a_al, y_al;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= QW'(Q_RST);
      p_q <= PW'(P_RST);
      a_q <= PW'(A_RST);
      y_q <= PW'(Y_RST);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_Q:   q_q <= cfg_wdata_i[QW-1:0];
        CFG_P:   p_q <= cfg_wdata_i[PW-1:0];
        CFG_A:   a_q <= cfg_wdata_i[PW-1:0];
        CFG_Y:   y_q <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign range_bad = (r_value_i == '0) || (r_value_i >= RS_W'(q_q))
                  || (s_value_i == '0) || (s_value_i >= RS_W'(q_q));
  assign p_small   = p_q < PW'(2);
  assign one_m     = MW'(1);
  assign q_m       = MW'(q_q);
  assign p_m       = MW'(p_q);
  assign res_al    = DIG_W'(mm_res) << (DIG_W - MW);
  assign inv_al    = DIG_W'(eu_inv) << (DIG_W - QW);
  assign one_al    = DIG_W'(one_m) << (DIG_W - MW);
  assign a_al      = DIG_W'(MW'(a_q)) << (DIG_W - MW);
  assign y_al      = DIG_W'(MW'(y_q)) << (DIG_W - MW);
  assign ebit      = sel_q ? u2_q[idx_q] : u1_q[idx_q];
  assign base      = sel_q ? by_q : ba_q;
  assign eu_h      = mm_res[QW-1:0] + QW'(1);

  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    s_d      = s_q;
    u1_d     = u1_q;
    u2_d     = u2_q;
    ba_d     = ba_q;
    by_d     = by_q;
    pa_d     = pa_q;
    idx_d    = idx_q;
    sel_d    = sel_q;
    done_d   = 1'b0;
    sig_d    = sig_q;
    fault_d  = fault_q;
    mm_req   = '0;
    mm_x     = '0;
    mm_y     = '0;
    mm_m     = '0;
    eu_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          r_d = r_value_i[QW-1:0];
          s_d = s_value_i[QW-1:0];
          if (range_bad) begin
            done_d  = 1'b1;
            sig_d   = 1'b0;
            fault_d = 1'b1;
          end else begin
            // h - 1 = digest mod (q-1)
            mm_req.start = 1'b1;
            mm_req.nbits = CNT_W'(DIG_W);
            mm_x         = one_m;
            mm_y         = digest_i;
            mm_m         = MW'(q_q - QW'(1));
            state_d      = ST_DIGEST;
          end
        end
      end
      ST_DIGEST: begin
        if (mm_done) begin
          eu_start = 1'b1;
          state_d  = ST_EUCLID;
        end
      end
      ST_EUCLID: begin
        if (eu_done) begin
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(QW);
          mm_x         = MW'(s_q);
          mm_y         = inv_al;
          mm_m         = q_m;
          state_d      = ST_U1;
        end
      end
      ST_U1: begin
        if (mm_done) begin
          u1_d         = mm_res[QW-1:0];
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(QW);
          mm_x         = MW'(q_q - r_q);
          mm_y         = inv_al;
          mm_m         = q_m;
          state_d      = ST_U2;
        end
      end
      ST_U2: begin
        if (mm_done) begin
          u2_d = mm_res[QW-1:0];
          if (p_small) begin
            done_d  = 1'b1;
            sig_d   = 1'b0;
            fault_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            mm_req.start = 1'b1;
            mm_req.nbits = CNT_W'(MW);
            mm_x         = one_m;
            mm_y         = a_al;
            mm_m         = p_m;
            state_d      = ST_RED_A;
          end
        end
      end
      ST_RED_A: begin
        if (mm_done) begin
          ba_d         = mm_res;
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(MW);
          mm_x         = one_m;
          mm_y         = y_al;
          mm_m         = p_m;
          state_d      = ST_RED_Y;
        end
      end
      ST_RED_Y: begin
        if (mm_done) begin
          by_d         = mm_res;
          sel_d        = 1'b0;
          idx_d        = IW'(QW - 1);
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(MW);
          mm_x         = one_m;
          mm_y         = one_al;
          mm_m         = p_m;
          state_d      = ST_SQR;
        end
      end
      ST_SQR, ST_MUL: begin
        if (mm_done) begin
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(MW);
          mm_m         = p_m;
          if (state_q == ST_SQR && ebit) begin
            mm_x    = base;
            mm_y    = res_al;
            state_d = ST_MUL;
          end else if (idx_q != '0) begin
            idx_d   = idx_q - IW'(1);
            mm_x    = mm_res;
            mm_y    = res_al;
            state_d = ST_SQR;
          end else if (!sel_q) begin
            // first power done, start y^u2
            pa_d    = mm_res;
            sel_d   = 1'b1;
            idx_d   = IW'(QW - 1);
            mm_x    = one_m;
            mm_y    = one_al;
            state_d = ST_SQR;
          end else begin
            mm_x    = pa_q;
            mm_y    = res_al;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (mm_done) begin
          mm_req.start = 1'b1;
          mm_req.nbits = CNT_W'(MW);
          mm_x         = one_m;
          mm_y         = res_al;
          mm_m         = q_m;
          state_d      = ST_VMOD;
        end
      end
      ST_VMOD: begin
        if (mm_done) begin
          done_d  = 1'b1;
          sig_d   = mm_res == MW'(r_q);
          fault_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      sig_q   <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sig_q   <= sig_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    s_q   <= s_d;
    u1_q  <= u1_d;
    u2_q  <= u2_d;
    ba_q  <= ba_d;
    by_q  <= by_d;
    pa_q  <= pa_d;
    idx_q <= idx_d;
    sel_q <= sel_d;
  end

  gsv_modmul #(
    .MW(MW)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .x_i    (mm_x),
    .m_i    (mm_m),
    .y_i    (mm_y),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  gsv_euclid #(
    .QW(QW)
  ) u_euclid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eu_start),
    .h_i     (eu_h),
    .q_i     (q_q),
    .done_o  (eu_done),
    .inv_o   (eu_inv)
  );

  assign busy_o        = state_q != ST_IDLE;
  assign done_o        = done_q;
  assign sig_valid_o   = sig_q;
  assign range_fault_o = fault_q;

  a_fault_no_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(sig_valid_o && range_fault_o))
    else $error("signature reported valid with range fault");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result given while still busy");

  a_bad_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && range_bad) |=> (done_o && range_fault_o))
    else $error("range fault not reported on next cycle");

endmodule
